// ----- src/phase_current_offset_calibrator_macros.svh -----
// Assertion macros used by the calibrator top module.
`ifndef PHASE_CURRENT_OFFSET_CALIBRATOR_MACROS_SVH
`define PHASE_CURRENT_OFFSET_CALIBRATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCOC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pcoc assertion failed");

// Next-cycle implication, checked outside reset.
`define PCOC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pcoc assertion failed");

`endif

// ----- src/pcoc_pkg.sv -----
package pcoc_pkg;

    localparam int ADC_BITS  = 14;
    localparam int CURRENT_W = 19;
    localparam int LANES     = 3;
    localparam int INSTANCES = 2;
    localparam int CFG_W     = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [CFG_W-1:0]    CAL_COUNT_RESET = CFG_W'(500);
    localparam logic [CFG_W-1:0]    WEIGHT_RESET    = CFG_W'(3277);
    localparam logic [ADC_BITS-1:0] OFFSET_RESET    = ADC_BITS'(8196);

    // Register index, taken from paddr[2].
    localparam logic REG_CAL_COUNT  = 1'b0;
    localparam logic REG_AVG_WEIGHT = 1'b1;

    typedef logic [ADC_BITS-1:0]         sample_t;
    typedef logic signed [CURRENT_W-1:0] current_t;
    typedef logic [CFG_W-1:0]            cfg_t;

    typedef struct packed {
        logic    instance_req;
        sample_t sample_a;
        sample_t sample_b;
        sample_t sample_c;
    } sample_set_t;

    typedef struct packed {
        current_t current_a;
        current_t current_b;
        current_t current_c;
        logic     calibrating;
    } current_set_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic inst;
    } lane_ctl_t;

endpackage

// ----- src/phase_current_offset_calibrator.sv -----
// Channel  | Handshake                    | Item
// ---------+------------------------------+--------------------------------------
// samples  | sample_valid / sample_stall  | sample_set: instance, phases A, B, C
// currents | current_valid / current_stall| current_set: currents A, B, C, flag
// config   | APB psel/penable/pwrite      | calibration_count, average_weight
//
// One item per cycle is accepted while sample_stall is low; results are registered.
// The offset update (one multiply per phase lane) finishes in the accept cycle,
// so items for the same instance follow each other without gaps.
// Reset clears the item counter, sets all six offsets to 8196 and loads the
// register reset values; no clearing pass is needed.
// A stalled result is held while one more item is taken into the lane stage.
module phase_current_offset_calibrator
    import pcoc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  sample_set_t        sample_set,
    output logic               current_valid,
    input  logic               current_stall,
    output current_set_t       current_set,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    `include "phase_current_offset_calibrator_macros.svh"

    cfg_t      cal_count_reg;
    cfg_t      weight_reg;
    cfg_t      items_seen_reg;
    logic      stage_valid_reg;
    logic      stage_cal_reg;

    logic      accept;
    logic      update;
    logic      advance;
    logic      cfg_write;
    lane_ctl_t ctl;
    sample_t   samples      [LANES];
    sample_t   stage_offset [LANES];
    sample_t   stage_sample [LANES];

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_count_reg <= CAL_COUNT_RESET;
            weight_reg    <= WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_CAL_COUNT:  cal_count_reg <= pwdata[CFG_W-1:0];
                REG_AVG_WEIGHT: weight_reg    <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CAL_COUNT:  prdata = APB_DW'(cal_count_reg);
            REG_AVG_WEIGHT: prdata = APB_DW'(weight_reg);
            default:        prdata = '0;
        endcase
    end

    // Input side and calibration counter.
    assign sample_stall = stage_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;
    assign update       = items_seen_reg < cal_count_reg;

    assign ctl.accept = accept;
    assign ctl.update = update;
    assign ctl.inst   = sample_set.instance_req;

    assign samples[0] = sample_set.sample_a;
    assign samples[1] = sample_set.sample_b;
    assign samples[2] = sample_set.sample_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_seen_reg  <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && update)
            begin
                items_seen_reg <= items_seen_reg + CFG_W'(1);
            end
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_cal_reg <= update;
        end
    end

    for (genvar p = 0; p < LANES; p++)
    begin : g_lane
        pcoc_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .sample       (samples[p]),
            .weight       (weight_reg),
            .stage_offset (stage_offset[p]),
            .stage_sample (stage_sample[p])
        );
    end

    pcoc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid_reg),
        .stage_cal    (stage_cal_reg),
        .stage_offset (stage_offset),
        .stage_sample (stage_sample),
        .out_stall    (current_stall),
        .advance      (advance),
        .out_valid    (current_valid),
        .out_item     (current_set)
    );

    `PCOC_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, accept, stage_valid_reg)
    `PCOC_ASSERT_NEXT(a_count_steps, clk, rst_n, accept && update,
        items_seen_reg == $past(items_seen_reg) + CFG_W'(1))
    `PCOC_ASSERT_NEXT(a_count_holds, clk, rst_n, !(accept && update),
        $stable(items_seen_reg))
    `PCOC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, sample_stall,
        stage_valid_reg && current_valid)

endmodule

// ----- src/pcoc_lane.sv -----
module pcoc_lane
    import pcoc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lane_ctl_t ctl,
    input  sample_t   sample,
    input  cfg_t      weight,
    output sample_t   stage_offset,
    output sample_t   stage_sample
);

    localparam int DiffW = ADC_BITS + 1;
    localparam int WgtW  = CFG_W + 1;
    localparam int ProdW = DiffW + WgtW;

    sample_t offset_reg [INSTANCES];
    sample_t stage_offset_reg;
    sample_t stage_sample_reg;

    sample_t                  offset_cur;
    logic signed [DiffW-1:0]  diff;
    logic signed [WgtW-1:0]   wgt;
    logic signed [ProdW-1:0]  prod;
    logic        [DiffW-1:0]  delta;
    sample_t                  offset_next;

    assign offset_cur = offset_reg[ctl.inst];

    // The average is rewritten as offset + floor((sample - offset) * w / 2^16),
    // which needs one signed multiply. Taking the upper bits floors.
    assign diff  = signed'({1'b0, sample}) - signed'({1'b0, offset_cur});
    assign wgt   = signed'({1'b0, weight});
    assign prod  = ProdW'(diff) * ProdW'(wgt);
    assign delta = prod[CFG_W +: DiffW];

    always_comb
    begin
        if (ctl.update)
        begin
            offset_next = offset_cur + delta[ADC_BITS-1:0];
        end
        else
        begin
            offset_next = offset_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < INSTANCES; i++)
            begin
                offset_reg[i] <= OFFSET_RESET;
            end
        end
        else if (ctl.accept && ctl.update)
        begin
            offset_reg[ctl.inst] <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            stage_offset_reg <= offset_next;
            stage_sample_reg <= sample;
        end
    end

    assign stage_offset = stage_offset_reg;
    assign stage_sample = stage_sample_reg;

endmodule

// ----- src/pcoc_merge.sv -----
module pcoc_merge
    import pcoc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         stage_valid,
    input  logic         stage_cal,
    input  sample_t      stage_offset [LANES],
    input  sample_t      stage_sample [LANES],
    input  logic         out_stall,
    output logic         advance,
    output logic         out_valid,
    output current_set_t out_item
);

    localparam int DiffW = ADC_BITS + 1;
    localparam int CalcW = (ADC_BITS + 5 > CURRENT_W) ? ADC_BITS + 5 : CURRENT_W;

    logic         out_valid_reg;
    current_set_t out_reg;
    current_t     cur [LANES];

    // (offset - sample) * 10 as two shifted adds, wrapped to the output width.
    always_comb
    begin
        logic signed [DiffW-1:0] d;
        logic signed [CalcW-1:0] dx;
        logic signed [CalcW-1:0] scaled;
        for (int p = 0; p < LANES; p++)
        begin
            d      = signed'({1'b0, stage_offset[p]}) - signed'({1'b0, stage_sample[p]});
            dx     = CalcW'(d);
            scaled = (dx <<< 3) + (dx <<< 1);
            cur[p] = scaled[CURRENT_W-1:0];
        end
    end

    assign advance = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            out_reg.current_a   <= cur[0];
            out_reg.current_b   <= cur[1];
            out_reg.current_c   <= cur[2];
            out_reg.calibrating <= stage_cal;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ----- tb/phase_current_offset_calibrator_tb.sv -----
module phase_current_offset_calibrator_tb
    import pcoc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               sample_valid  = 1'b0;
    logic               sample_stall;
    sample_set_t        sample_set    = '0;
    logic               current_valid;
    logic               current_stall = 1'b0;
    current_set_t       current_set;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [APB_AW-1:0]  paddr         = '0;
    logic [APB_DW-1:0]  pwdata        = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    phase_current_offset_calibrator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_set    (sample_set),
        .current_valid (current_valid),
        .current_stall (current_stall),
        .current_set   (current_set),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Mirror of the calibrator state.
    sample_t      offset_mirror [INSTANCES*LANES];
    logic [15:0]  items_counted;
    cfg_t         cal_count_setting;
    cfg_t         weight_setting;

    sample_set_t  pending_sets [$];
    current_set_t expected_currents [$];
    current_set_t want_set;

    int  error_count     = 0;
    int  send_gap        = 0;
    int  stall_left      = 0;
    int  results_taken   = 0;
    bit  long_hold_done  = 1'b0;
    bit  quiet           = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("phase_current_offset_calibrator_tb: errors");
        $finish;
    end

    // Moves the addressed offsets toward the samples while calibration runs,
    // then forms the currents from the offsets as they stand afterward.
    function automatic current_set_t compute_currents(sample_set_t s);
        current_set_t res;
        sample_t      smp [LANES];
        logic [47:0]  acc;
        int           base;
        bit           cal;
        base   = s.instance_req ? LANES : 0;
        smp[0] = s.sample_a;
        smp[1] = s.sample_b;
        smp[2] = s.sample_c;
        cal    = (items_counted < cal_count_setting);
        if (cal)
        begin
            for (int p = 0; p < LANES; p++)
            begin
                acc = 48'(smp[p]) * 48'(weight_setting)
                    + 48'(offset_mirror[base+p]) * (48'd65536 - 48'(weight_setting));
                offset_mirror[base+p] = acc[16 +: ADC_BITS];
            end
            items_counted = items_counted + 16'd1;
        end
        res.current_a   = CURRENT_W'((int'(offset_mirror[base]) - int'(smp[0])) * 10);
        res.current_b   = CURRENT_W'((int'(offset_mirror[base+1]) - int'(smp[1])) * 10);
        res.current_c   = CURRENT_W'((int'(offset_mirror[base+2]) - int'(smp[2])) * 10);
        res.calibrating = cal;
        return res;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void add_set(logic inst, sample_t a, sample_t b, sample_t c);
        sample_set_t s;
        s.instance_req = inst;
        s.sample_a     = a;
        s.sample_b     = b;
        s.sample_c     = c;
        pending_sets.push_back(s);
    endfunction

    // Half the samples sit near the zero-current level, half span the full range.
    function automatic sample_t pick_sample();
        if ($urandom_range(0, 1))
            return sample_t'($urandom);
        return sample_t'(int'(OFFSET_RESET) - 256 + int'($urandom_range(0, 511)));
    endfunction

    function automatic void add_random_sets(int n);
        repeat (n)
            add_set(1'($urandom), pick_sample(), pick_sample(), pick_sample());
    endfunction

    task automatic write_calibration_reg(input logic reg_idx, input cfg_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_CAL_COUNT)
            cal_count_setting = value;
        else
            weight_setting = value;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_sets.size() != 0 || sample_valid || expected_currents.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Sample side: one item per handshake, random gaps between items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_set   <= '0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                expected_currents.push_back(compute_currents(sample_set));
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_sets.size() > 0)
                begin
                    sample_set   <= pending_sets.pop_front();
                    sample_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 8);
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Current side: checks each result and stalls at random, once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            current_stall <= 1'b0;
        else
        begin
            if (current_valid && !current_stall)
            begin
                results_taken++;
                if (expected_currents.size() == 0)
                    note_mismatch("result with nothing pending", 0, 0);
                else
                begin
                    want_set = expected_currents.pop_front();
                    if (current_set.current_a !== want_set.current_a)
                        note_mismatch("current_a", current_set.current_a, want_set.current_a);
                    if (current_set.current_b !== want_set.current_b)
                        note_mismatch("current_b", current_set.current_b, want_set.current_b);
                    if (current_set.current_c !== want_set.current_c)
                        note_mismatch("current_c", current_set.current_c, want_set.current_c);
                    if (current_set.calibrating !== want_set.calibrating)
                        note_mismatch("calibrating", current_set.calibrating,
                                      want_set.calibrating);
                end
            end
            if (!long_hold_done && results_taken >= 120)
            begin
                long_hold_done = 1'b1;
                stall_left = 60;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                stall_left--;
                current_stall <= 1'b1;
            end
            else
                current_stall <= 1'b0;
        end
    end

    initial
    begin
        for (int i = 0; i < INSTANCES*LANES; i++)
            offset_mirror[i] = OFFSET_RESET;
        items_counted     = '0;
        cal_count_setting = CAL_COUNT_RESET;
        weight_setting    = WEIGHT_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes and bit patterns on both instances, under reset settings.
        add_set(1'b0, 14'd0, 14'd0, 14'd0);
        add_set(1'b1, 14'd16383, 14'd16383, 14'd16383);
        add_set(1'b0, 14'd16383, 14'd16383, 14'd16383);
        add_set(1'b1, 14'd0, 14'd0, 14'd0);
        add_set(1'b0, OFFSET_RESET, OFFSET_RESET, OFFSET_RESET);
        add_set(1'b1, OFFSET_RESET, 14'd0, 14'd16383);
        add_set(1'b0, 14'h2AAA, 14'h1555, 14'h2AAA);
        add_set(1'b1, 14'h1555, 14'h2AAA, 14'h1555);
        add_set(1'b0, 14'd1, 14'd16382, 14'd8192);
        add_set(1'b1, 14'd8191, 14'd8192, 14'd8193);
        add_set(1'b0, 14'd16383, 14'd0, 14'd16383);
        add_set(1'b0, 14'd0, 14'd16383, 14'd0);
        add_set(1'b1, 14'd16383, 14'd16383, 14'd0);
        add_set(1'b1, 14'd0, 14'd0, 14'd16383);
        add_random_sets(6);
        add_random_sets(300);
        wait_drained();

        // A zero weight keeps the offsets while the counter still runs.
        write_calibration_reg(REG_AVG_WEIGHT, 16'd0);
        write_calibration_reg(REG_CAL_COUNT, 16'hFFFF);
        add_random_sets(150);
        wait_drained();

        write_calibration_reg(REG_AVG_WEIGHT, 16'hFFFF);
        add_random_sets(150);
        wait_drained();

        // A count of zero never averages.
        write_calibration_reg(REG_CAL_COUNT, 16'd0);
        add_random_sets(150);
        wait_drained();

        // Averaging resumes for the items still below the raised count, then stops.
        write_calibration_reg(REG_CAL_COUNT, 16'd700);
        write_calibration_reg(REG_AVG_WEIGHT, 16'd20000);
        add_random_sets(200);
        wait_drained();

        write_calibration_reg(REG_CAL_COUNT, CAL_COUNT_RESET);
        write_calibration_reg(REG_AVG_WEIGHT, WEIGHT_RESET);
        add_random_sets(150);
        wait_drained();

        quiet = 1'b1;
        write_calibration_reg(REG_CAL_COUNT, 16'hFFFF);
        write_calibration_reg(REG_AVG_WEIGHT, cfg_t'($urandom));
        add_random_sets(150);
        wait_drained();
        repeat (10) @(negedge clk);

        if (error_count == 0)
            $display("phase_current_offset_calibrator_tb: clean");
        else
            $display("phase_current_offset_calibrator_tb: errors");
        $finish;
    end

endmodule
